// File: hdl/lpps_pkg.sv
// lpps_pkg: shared constants, control word types and microcode ROM for the
// LCD pixel plot serial block. No dependencies.
`default_nettype none
package lpps_pkg;

	// Geometry of the shadow store
	localparam int HALF_ROWS    = 32;
	localparam int WORD_COLUMNS = 16;
	localparam int FOLD_OFFSET  = WORD_COLUMNS / 2;
	localparam int X_LIMIT      = FOLD_OFFSET * 16 - 1;
	localparam int Y_LIMIT      = 2 * HALF_ROWS - 1;
	localparam int DEPTH        = HALF_ROWS * WORD_COLUMNS;

	localparam int ROW_W = (HALF_ROWS > 1) ? $clog2(HALF_ROWS) : 1;
	localparam int COL_W = $clog2(WORD_COLUMNS);
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Configuration register indexes and reset values
	localparam logic [7:0] CFG_SYNC_CMD  = 8'd0;
	localparam logic [7:0] CFG_SYNC_DATA = 8'd1;
	localparam logic [7:0] CFG_GRAM_BASE = 8'd2;

	localparam logic [7:0] RST_SYNC_CMD  = 8'hF8;
	localparam logic [7:0] RST_SYNC_DATA = 8'hFA;
	localparam logic [7:0] RST_GRAM_BASE = 8'h80;

	// Microprogram
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
	localparam logic [STEP_W-1:0] ST_READ   = 4'd1;
	localparam logic [STEP_W-1:0] ST_MODIFY = 4'd2;
	localparam logic [STEP_W-1:0] ST_REJECT = 4'd15;

	typedef enum logic [1:0] {
		SRC_ROW = 2'd0,
		SRC_COL = 2'd1,
		SRC_HI  = 2'd2,
		SRC_LO  = 2'd3
	} src_sel_t;

	typedef enum logic [1:0] {
		PART_SYNC = 2'd0,
		PART_HIGH = 2'd1,
		PART_LOW  = 2'd2
	} part_sel_t;

	typedef struct packed {
		logic      wait_in;    // hold until a request is taken
		logic      mem_rd;     // read shadow word, latch address
		logic      mem_wr;     // write modified word back
		logic      emit;       // push one result, hold while output full
		logic      rej;        // result is the reject marker
		src_sel_t  src;
		part_sel_t part;
		logic      sync_data;  // data sync instead of command sync
		logic      last;
		logic      br_reject;  // jump to reject step when request was out of range
		logic      br_home;    // jump to idle after this step
	} ucode_t;

	typedef struct packed {
		logic in_acc;
		logic out_free;
		logic reject;
	} seq_stat_t;

	function automatic ucode_t emit_word(src_sel_t s, part_sel_t p, logic d, logic l);
		ucode_t u;
		u           = '0;
		u.emit      = 1'b1;
		u.src       = s;
		u.part      = p;
		u.sync_data = d;
		u.last      = l;
		u.br_home   = l;
		return u;
	endfunction

	function automatic ucode_t ucode_rom(logic [STEP_W-1:0] step);
		ucode_t u;
		u = '0;
		unique case (step)
			ST_IDLE: begin
				u.wait_in = 1'b1;
			end
			ST_READ: begin
				u.mem_rd    = 1'b1;
				u.br_reject = 1'b1;
			end
			ST_MODIFY: begin
				u.mem_wr = 1'b1;
			end
			4'd3:  u = emit_word(SRC_ROW, PART_SYNC, 1'b0, 1'b0);
			4'd4:  u = emit_word(SRC_ROW, PART_HIGH, 1'b0, 1'b0);
			4'd5:  u = emit_word(SRC_ROW, PART_LOW,  1'b0, 1'b0);
			4'd6:  u = emit_word(SRC_COL, PART_SYNC, 1'b0, 1'b0);
			4'd7:  u = emit_word(SRC_COL, PART_HIGH, 1'b0, 1'b0);
			4'd8:  u = emit_word(SRC_COL, PART_LOW,  1'b0, 1'b0);
			4'd9:  u = emit_word(SRC_HI,  PART_SYNC, 1'b1, 1'b0);
			4'd10: u = emit_word(SRC_HI,  PART_HIGH, 1'b1, 1'b0);
			4'd11: u = emit_word(SRC_HI,  PART_LOW,  1'b1, 1'b0);
			4'd12: u = emit_word(SRC_LO,  PART_SYNC, 1'b1, 1'b0);
			4'd13: u = emit_word(SRC_LO,  PART_HIGH, 1'b1, 1'b0);
			4'd14: u = emit_word(SRC_LO,  PART_LOW,  1'b1, 1'b1);
			ST_REJECT: begin
				u.emit    = 1'b1;
				u.rej     = 1'b1;
				u.last    = 1'b1;
				u.br_home = 1'b1;
			end
			default: u = '0;
		endcase
		return u;
	endfunction

endpackage
`default_nettype wire

// File: hdl/lpps_useq.sv
// lpps_useq: step counter and microcode fetch with conditional jumps.
// Depends on lpps_pkg.
`default_nettype none
module lpps_useq
	import lpps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire seq_stat_t stat,
	output ucode_t         ctrl
);

	logic [STEP_W-1:0] step_q;
	logic              hold;

	assign ctrl = ucode_rom(step_q);
	assign hold = (ctrl.wait_in && !stat.in_acc) || (ctrl.emit && !stat.out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
		end else if (!hold) begin
			priority if (ctrl.br_reject && stat.reject) begin
				step_q <= ST_REJECT;
			end else if (ctrl.br_home) begin
				step_q <= ST_IDLE;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/lpps_datapath.sv
// lpps_datapath: request registers, shadow word store with clearing pass,
// read-modify-write and serial byte formation. Depends on lpps_pkg.
`default_nettype none
module lpps_datapath
	import lpps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ucode_t     ctrl,
	input  wire logic       in_acc,
	input  wire logic [7:0] pixel_x,
	input  wire logic [7:0] pixel_y,
	input  wire logic [7:0] pixel_value,
	input  wire logic [7:0] sync_cmd,
	input  wire logic [7:0] sync_data,
	input  wire logic [7:0] gram_base,
	output logic            reject,
	output logic            clear_done,
	output logic [7:0]      byte_d,
	output logic            accepted_d,
	output logic            last_d
);

	logic [15:0]      mem [DEPTH];

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [3:0]       xbit_q;
	logic             set_q;
	logic             reject_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      rdata_q;
	logic [15:0]      word_q;
	logic [IDX_W-1:0] clr_cnt_q;
	logic             clr_done_q;

	logic             in_range;
	logic             fold;
	logic [7:0]       y_fold;
	logic [7:0]       col_full;
	logic [15:0]      idx_full;
	logic [IDX_W-1:0] idx_calc;
	logic [15:0]      mask;
	logic [15:0]      new_word;
	logic [7:0]       src_byte;

	// Request decode at accept
	assign in_range = (pixel_x <= 8'(X_LIMIT)) && (pixel_y <= 8'(Y_LIMIT));
	assign fold     = pixel_y >= 8'(HALF_ROWS);
	assign y_fold   = fold ? (pixel_y - 8'(HALF_ROWS)) : pixel_y;
	assign col_full = {4'd0, pixel_x[7:4]} + (fold ? 8'(FOLD_OFFSET) : 8'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reject_q <= 1'b0;
		end else if (in_acc) begin
			reject_q <= !in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q  <= y_fold[ROW_W-1:0];
			col_q  <= col_full[COL_W-1:0];
			xbit_q <= pixel_x[3:0];
			set_q  <= |pixel_value;
		end
	end

	assign reject = reject_q;

	// Word address
	assign idx_full = 16'(row_q) * 16'(WORD_COLUMNS) + 16'(col_q);
	assign idx_calc = (idx_full >= 16'(DEPTH)) ? '0 : idx_full[IDX_W-1:0];

	assign mask     = 16'h8000 >> xbit_q;
	assign new_word = set_q ? (rdata_q | mask) : (rdata_q & ~mask);

	// Clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clr_done_q <= 1'b0;
		end else if (!clr_done_q) begin
			if (clr_cnt_q == IDX_W'(DEPTH - 1)) begin
				clr_done_q <= 1'b1;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	assign clear_done = clr_done_q;

	// Shadow store
	always_ff @(posedge clk) begin
		if (!clr_done_q) begin
			mem[clr_cnt_q] <= '0;
		end else if (ctrl.mem_wr) begin
			mem[idx_q] <= new_word;
		end
		if (ctrl.mem_rd) begin
			rdata_q <= mem[idx_calc];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.mem_rd) begin
			idx_q <= idx_calc;
		end
		if (ctrl.mem_wr) begin
			word_q <= new_word;
		end
	end

	// Byte formation
	always_comb begin
		unique case (ctrl.src)
			SRC_ROW: src_byte = gram_base + 8'(row_q);
			SRC_COL: src_byte = gram_base + 8'(col_q);
			SRC_HI:  src_byte = word_q[15:8];
			SRC_LO:  src_byte = word_q[7:0];
			default: src_byte = word_q[7:0];
		endcase
	end

	always_comb begin
		if (ctrl.rej) begin
			byte_d = 8'd0;
		end else begin
			unique case (ctrl.part)
				PART_SYNC: byte_d = ctrl.sync_data ? sync_data : sync_cmd;
				PART_HIGH: byte_d = src_byte & 8'hF0;
				PART_LOW:  byte_d = {src_byte[3:0], 4'd0};
				default:   byte_d = 8'd0;
			endcase
		end
	end

	assign accepted_d = !ctrl.rej;
	assign last_d     = ctrl.last;

endmodule
`default_nettype wire

// File: hdl/lcd_pixel_plot_serial_top.sv
// lcd_pixel_plot_serial_top: top level with configuration registers and the
// output register. Depends on lpps_pkg, lpps_useq and lpps_datapath.
`default_nettype none
// Plots one pixel per request into a 128x64 monochrome shadow framebuffer kept
// as 512 words of 16 bits (the lower half of the screen folds onto word
// columns 8..15), then sends twelve serial bytes: row address command, column
// address command, high data byte, low data byte, each as sync byte, high
// nibble, low nibble shifted up. An out-of-range request gets one result with
// serial_byte 0, accepted 0 and last_byte 1, and leaves the store untouched.
// After reset the store is cleared, one word per cycle; pix requests are
// stalled until then, configuration writes are taken at once. The microcode
// step counter runs a pixel request through one accept step, one store read,
// one write-back and twelve emit steps, a rejected request through the accept,
// read and reject steps; an emit step waits while the output register is full.
// The final result waits in the output register while the next request is accepted.
module lcd_pixel_plot_serial_top
	import lpps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	// pixel request channel
	input  wire logic       pix_valid,
	output logic            pix_stall,
	input  wire logic [7:0] pixel_x,
	input  wire logic [7:0] pixel_y,
	input  wire logic [7:0] pixel_value,
	// serial result channel
	output logic            ser_valid,
	input  wire logic       ser_stall,
	output logic [7:0]      serial_byte,
	output logic            accepted,
	output logic            last_byte,
	// configuration write channel
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_index,
	input  wire logic [7:0] cfg_data
);

	ucode_t     ctrl;
	seq_stat_t  stat;
	logic       in_acc;
	logic       out_free;
	logic       reject;
	logic       clear_done;
	logic [7:0] byte_d;
	logic       accepted_d;
	logic       last_d;
	logic       emit_fire;

	logic [7:0] sync_cmd_q;
	logic [7:0] sync_data_q;
	logic [7:0] gram_base_q;
	logic       ser_valid_q;
	logic [7:0] ser_byte_q;
	logic       ser_acc_q;
	logic       ser_last_q;

	// Configuration registers; writes are always taken, unknown indexes dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_cmd_q  <= RST_SYNC_CMD;
			sync_data_q <= RST_SYNC_DATA;
			gram_base_q <= RST_GRAM_BASE;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_SYNC_CMD) begin
				sync_cmd_q <= cfg_data;
			end
			if (cfg_index == CFG_SYNC_DATA) begin
				sync_data_q <= cfg_data;
			end
			if (cfg_index == CFG_GRAM_BASE) begin
				gram_base_q <= cfg_data;
			end
		end
	end

	// Request side: only the idle step takes a request, and not during clearing
	assign pix_stall = !(ctrl.wait_in && clear_done);
	assign in_acc    = pix_valid && !pix_stall;

	// Output register frees when empty or being drained this cycle
	assign out_free  = !ser_valid_q || !ser_stall;
	assign emit_fire = ctrl.emit && out_free;

	assign stat.in_acc   = in_acc;
	assign stat.out_free = out_free;
	assign stat.reject   = reject;

	lpps_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	lpps_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_acc      (in_acc),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.sync_cmd    (sync_cmd_q),
		.sync_data   (sync_data_q),
		.gram_base   (gram_base_q),
		.reject      (reject),
		.clear_done  (clear_done),
		.byte_d      (byte_d),
		.accepted_d  (accepted_d),
		.last_d      (last_d)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_valid_q <= 1'b0;
		end else if (emit_fire) begin
			ser_valid_q <= 1'b1;
		end else if (!ser_stall) begin
			ser_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_fire) begin
			ser_byte_q <= byte_d;
			ser_acc_q  <= accepted_d;
			ser_last_q <= last_d;
		end
	end

	assign ser_valid   = ser_valid_q;
	assign serial_byte = ser_byte_q;
	assign accepted    = ser_acc_q;
	assign last_byte   = ser_last_q;

endmodule
`default_nettype wire

// File: tb/pixel_sb_pkg.sv
// pixel_sb_pkg: scoreboard for the LCD pixel plot serial block. It predicts
// the serial beats of each pixel request and checks the beats that come out.
// Depends on lpps_pkg for geometry and register indexes.
`timescale 1ns / 100ps
package pixel_sb_pkg;
	import lpps_pkg::*;

	typedef struct packed {
		logic [7:0] sbyte;
		logic       acc;
		logic       last;
	} serial_beat_t;

	class pixel_shadow_sb;
		logic [15:0]  shadow_words [DEPTH];
		logic [7:0]   sync_cmd;
		logic [7:0]   sync_data;
		logic [7:0]   gram_base;
		serial_beat_t expected_beats [$];
		int           errors;
		int           requests;
		int           beats_seen;

		function new();
			foreach (shadow_words[i]) shadow_words[i] = 16'h0000;
			sync_cmd   = RST_SYNC_CMD;
			sync_data  = RST_SYNC_DATA;
			gram_base  = RST_GRAM_BASE;
			errors     = 0;
			requests   = 0;
			beats_seen = 0;
		endfunction

		function void write_reg(logic [7:0] idx, logic [7:0] data);
			case (idx)
				CFG_SYNC_CMD:  sync_cmd  = data;
				CFG_SYNC_DATA: sync_data = data;
				CFG_GRAM_BASE: gram_base = data;
				default: ;
			endcase
		endfunction

		// one transfer: sync, high nibble, low nibble shifted up
		function void push_transfer(logic [7:0] sync, logic [7:0] b);
			expected_beats.push_back(serial_beat_t'{sync, 1'b1, 1'b0});
			expected_beats.push_back(serial_beat_t'{b & 8'hF0, 1'b1, 1'b0});
			expected_beats.push_back(serial_beat_t'{{b[3:0], 4'h0}, 1'b1, 1'b0});
		endfunction

		function void note_request(logic [7:0] x, logic [7:0] y, logic [7:0] v);
			logic [15:0]  mask;
			logic [15:0]  word;
			logic [7:0]   row_addr;
			logic [7:0]   col_addr;
			int           col;
			int           row;
			int           idx;
			serial_beat_t tail;
			requests++;
			if (x > X_LIMIT || y > Y_LIMIT) begin
				expected_beats.push_back(serial_beat_t'{8'h00, 1'b0, 1'b1});
				return;
			end
			mask = 16'h8000 >> x[3:0];
			col  = x / 16;
			row  = y;
			if (row >= HALF_ROWS) begin
				col += FOLD_OFFSET;
				row -= HALF_ROWS;
			end
			idx  = row * WORD_COLUMNS + col;
			word = shadow_words[idx];
			word = (v == 8'h00) ? (word & ~mask) : (word | mask);
			shadow_words[idx] = word;
			row_addr = gram_base + 8'(row);
			col_addr = gram_base + 8'(col);
			push_transfer(sync_cmd, row_addr);
			push_transfer(sync_cmd, col_addr);
			push_transfer(sync_data, word[15:8]);
			push_transfer(sync_data, word[7:0]);
			tail = expected_beats.pop_back();
			tail.last = 1'b1;
			expected_beats.push_back(tail);
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_beat(logic [7:0] b, logic acc, logic last);
			serial_beat_t want;
			beats_seen++;
			if (expected_beats.size() == 0) begin
				report($sformatf("unexpected beat byte=%02h acc=%0b last=%0b", b, acc, last));
				return;
			end
			want = expected_beats.pop_front();
			if (b !== want.sbyte)
				report($sformatf("beat %0d serial_byte %02h, want %02h", beats_seen, b,
					want.sbyte));
			if (acc !== want.acc)
				report($sformatf("beat %0d accepted %0b, want %0b", beats_seen, acc, want.acc));
			if (last !== want.last)
				report($sformatf("beat %0d last_byte %0b, want %0b", beats_seen, last,
					want.last));
		endtask

		function int outstanding();
			return expected_beats.size();
		endfunction

		task check_leftover();
			if (expected_beats.size() != 0)
				report($sformatf("%0d expected beats never arrived", expected_beats.size()));
		endtask
	endclass

endpackage

// File: tb/tb_top.sv
// tb_top: testbench for lcd_pixel_plot_serial_top. Drives pixel requests and
// register writes, stalls the serial output, checks every beat on the fly.
// Depends on lpps_pkg, pixel_sb_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_top;
	import lpps_pkg::*;
	import pixel_sb_pkg::*;

	localparam int CYCLE_LIMIT = 400000; // far above the slowest clean run
	localparam int HOLD_CYCLES = 300;    // long output hold, fills the block
	localparam int DRAIN_GAP   = 24;     // settle wait after the last beat is out
	localparam int RAND_PER_PHASE = 50;

	logic       clk;
	logic       arst_n;
	logic       pix_valid;
	logic       pix_stall;
	logic [7:0] pixel_x;
	logic [7:0] pixel_y;
	logic [7:0] pixel_value;
	logic       ser_valid;
	logic       ser_stall;
	logic [7:0] serial_byte;
	logic       accepted;
	logic       last_byte;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_index;
	logic [7:0] cfg_data;

	pixel_shadow_sb sb = new();

	// idle percentages per cycle, changed per phase by the main sequence
	int snd_idle_pct = 0;
	int rcv_idle_pct = 0;
	bit hold_req     = 1'b0;
	int cycle_count  = 0;

	lcd_pixel_plot_serial_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pix_valid   (pix_valid),
		.pix_stall   (pix_stall),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_value (pixel_value),
		.ser_valid   (ser_valid),
		.ser_stall   (ser_stall),
		.serial_byte (serial_byte),
		.accepted    (accepted),
		.last_byte   (last_byte),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost beat ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	// Monitor: every handshake is sampled at the rising edge, before the
	// block's own updates land, so the order of processes does not matter.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
			if (pix_valid && !pix_stall)
				sb.note_request(pixel_x, pixel_y, pixel_value);
			if (ser_valid && !ser_stall)
				sb.check_beat(serial_byte, accepted, last_byte);
		end
	end

	// Receiver: random stall per cycle, or a long hold when one is asked for.
	// The hold is counted here so the sender keeps offering requests meanwhile.
	initial begin
		int hold_left;
		hold_left = 0;
		ser_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				ser_stall <= 1'b1;
			end else begin
				ser_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
			end
		end
	end

	// Offer one request; valid stays high afterward so back-to-back requests
	// never drop valid between them. Gaps are inserted before the request.
	task send_pixel(input logic [7:0] x, input logic [7:0] y, input logic [7:0] v);
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			@(negedge clk);
			pix_valid <= 1'b0;
		end
		@(negedge clk);
		pix_valid   <= 1'b1;
		pixel_x     <= x;
		pixel_y     <= y;
		pixel_value <= v;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	task pixel_idle();
		@(negedge clk);
		pix_valid <= 1'b0;
	endtask

	// Random request: mostly in range, a share packed into a few words so
	// read-modify-write builds up, the rest rejects near and far from the edge.
	task send_random_pixel();
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] v;
		int         r;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			x = 8'($urandom);
			y = 8'($urandom);
		end else if (r < 16) begin
			x = $urandom_range(0, 1) ? 8'(X_LIMIT + 1) : 8'($urandom_range(0, X_LIMIT));
			y = (x > X_LIMIT) ? 8'($urandom_range(0, Y_LIMIT)) : 8'(Y_LIMIT + 1);
		end else if (r < 50) begin
			x = 8'($urandom_range(0, 31));
			case ($urandom_range(0, 3))
				0: y = 8'd0;
				1: y = 8'(HALF_ROWS - 1);
				2: y = 8'(HALF_ROWS);
				default: y = 8'(Y_LIMIT);
			endcase
		end else begin
			x = 8'($urandom_range(0, X_LIMIT));
			y = 8'($urandom_range(0, Y_LIMIT));
		end
		v = ($urandom_range(0, 99) < 40) ? 8'h00 : 8'($urandom_range(1, 255));
		send_pixel(x, y, v);
	endtask

	task write_cfg(input logic [7:0] idx, input logic [7:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only once every beat is out and the block has settled.
	task wait_drained();
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	initial begin
		int w;
		arst_n      = 1'b0;
		pix_valid   = 1'b0;
		pixel_x     = 8'h00;
		pixel_y     = 8'h00;
		pixel_value = 8'h00;
		cfg_valid   = 1'b0;
		cfg_index   = 8'h00;
		cfg_data    = 8'h00;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at reset register values: corner pixels, MSB and LSB
		// of a word, the fold onto the right half, clear and set again,
		// and rejects on x, on y and on both.
		snd_idle_pct = 0;
		rcv_idle_pct = 20;
		send_pixel(8'd0,   8'd0,  8'h01);
		send_pixel(8'd1,   8'd0,  8'h80);
		send_pixel(8'd15,  8'd0,  8'hFF);
		send_pixel(8'd16,  8'd0,  8'h01);
		send_pixel(8'd127, 8'd0,  8'h01);
		send_pixel(8'd0,   8'd31, 8'h01);
		send_pixel(8'd0,   8'd32, 8'h01);
		send_pixel(8'd127, 8'd63, 8'h01);
		send_pixel(8'd64,  8'd40, 8'h01);
		send_pixel(8'd0,   8'd0,  8'h00);
		send_pixel(8'd15,  8'd0,  8'h00);
		send_pixel(8'd127, 8'd63, 8'h00);
		send_pixel(8'd0,   8'd0,  8'h02);
		send_pixel(8'd128, 8'd0,  8'h01);
		send_pixel(8'd0,   8'd64, 8'h01);
		send_pixel(8'd255, 8'd255, 8'hFF);
		send_pixel(8'd128, 8'd64, 8'h00);
		send_pixel(8'd127, 8'd255, 8'h40);
		send_pixel(8'd255, 8'd63, 8'h20);
		send_pixel(8'd85,  8'd21, 8'h04);
		send_pixel(8'd42,  8'd42, 8'h08);
		send_pixel(8'd106, 8'd53, 8'h10);
		pixel_idle();
		wait_drained();

		// Phase 1: all-zero registers, an index past the list is ignored.
		// Sender idles lightly, receiver heavily.
		write_cfg(CFG_SYNC_CMD,  8'h00);
		write_cfg(CFG_SYNC_DATA, 8'h00);
		write_cfg(CFG_GRAM_BASE, 8'h00);
		write_cfg(CFG_GRAM_BASE + 8'd1, 8'h5A);
		snd_idle_pct = 10;
		rcv_idle_pct = 80;
		repeat (RAND_PER_PHASE) send_random_pixel();
		pixel_idle();
		wait_drained();

		// Phase 2: all-one registers, addresses wrap past 255.
		// Sender idles heavily, receiver lightly.
		write_cfg(CFG_SYNC_CMD,  8'hFF);
		write_cfg(CFG_SYNC_DATA, 8'hFF);
		write_cfg(CFG_GRAM_BASE, 8'hFF);
		write_cfg(8'hFF, 8'hA5);
		snd_idle_pct = 80;
		rcv_idle_pct = 10;
		repeat (RAND_PER_PHASE) send_random_pixel();
		pixel_idle();
		wait_drained();

		// Phase 3: random registers, no idling. A long output hold backs the
		// block up into its input; later the sender waits for a full drain.
		write_cfg(CFG_SYNC_CMD,  8'($urandom));
		write_cfg(CFG_SYNC_DATA, 8'($urandom));
		write_cfg(CFG_GRAM_BASE, 8'($urandom));
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		for (int i = 0; i < RAND_PER_PHASE; i++) begin
			if (i == 10)
				hold_req = 1'b1;
			if (i == 30) begin
				pixel_idle();
				while (sb.outstanding() != 0)
					@(posedge clk);
			end
			send_random_pixel();
		end
		pixel_idle();

		w = 0;
		while (sb.outstanding() != 0 && w < 20000) begin
			@(posedge clk);
			w++;
		end
		repeat (DRAIN_GAP) @(posedge clk);
		sb.check_leftover();

		$display("summary: %0d pixel requests (corners, folded rows, rejects), %0d beats checked",
			sb.requests, sb.beats_seen);
		$display("summary: reset, all-zero, all-one and random registers; long hold and drain");
		if (sb.errors == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

endmodule
